### hw/rtl/bsll_pkg.sv
`timescale 1ns / 1ps

package bsll_pkg;

  // default node store capacity
  localparam int BSLL_CAPACITY = 64;

  // action codes
  localparam logic [2:0] ACT_APPEND    = 3'd0;
  localparam logic [2:0] ACT_INS_HEAD  = 3'd1;
  localparam logic [2:0] ACT_INS_AFTER = 3'd2;
  localparam logic [2:0] ACT_DELETE    = 3'd3;
  localparam logic [2:0] ACT_SEARCH    = 3'd4;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_ALLOC_POP,
    S_WRITE,
    S_LINK2,
    S_DEL,
    S_DEL2,
    S_FINISH
  } state_t;

endpackage

### hw/rtl/bounded_singly_linked_list.sv
`timescale 1ns / 1ps

// Bounded singly linked list of signed 32-bit values held in a node store of
// CAPACITY entries (two RAMs for values and links, each with one write port and
// a registered read port) plus head, tail, free-list and count registers. One
// beat in carries an action (append, insert at head, insert after key, delete
// key, search key); one beat out returns a status and the node count after
// the action. The block takes one beat at a time: append and insert at head
// allocate a node (from the free list or untouched), write it and link it,
// and end at once when the store is full; search, delete and insert-after
// walk the list one node per cycle through the node store read port, visiting
// at most CAPACITY nodes, and an empty list or an unknown action goes straight
// to the result register. A result waits in the output register while the
// next beat is accepted. Freed nodes are reused before untouched ones; no
// clearing pass is needed after reset.
module bounded_singly_linked_list #(
  parameter int CAPACITY = bsll_pkg::BSLL_CAPACITY,
  parameter int IW       = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [IW-1:0]      out_count
);

  import bsll_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IW-1:0] NULL_IDX = IW'(CAPACITY);
  localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);

  state_t state_r, state_nxt;

  logic [2:0]    act_r, act_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic [IW-1:0] fresh_r, fresh_nxt;
  logic [IW-1:0] count_r, count_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] prev_r, prev_nxt;
  logic [IW-1:0] hit_r, hit_nxt;
  logic [IW-1:0] hit_link_r, hit_link_nxt;
  logic [IW-1:0] node_r, node_nxt;
  logic [IW-1:0] steps_r, steps_nxt;
  status_t       status_r, status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [IW-1:0] out_count_r, out_count_nxt;

  // node store ports
  logic          v_we;
  logic          l_we;
  logic [AW-1:0] l_waddr;
  logic [IW-1:0] l_wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   v_rdata;
  logic [IW-1:0] l_rdata;

  bsll_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (node_r[AW-1:0]),
    .wdata (val_r),
    .raddr (raddr),
    .rdata (v_rdata)
  );

  bsll_ram #(
    .WIDTH (IW),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (raddr),
    .rdata (l_rdata)
  );

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NULL_IDX;
      tail_r      <= NULL_IDX;
      free_r      <= NULL_IDX;
      fresh_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      fresh_r     <= fresh_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    hit_r        <= hit_nxt;
    hit_link_r   <= hit_link_nxt;
    node_r       <= node_nxt;
    steps_r      <= steps_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_nxt       = free_r;
    fresh_nxt      = fresh_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    hit_nxt        = hit_r;
    hit_link_nxt   = hit_link_r;
    node_nxt       = node_r;
    steps_nxt      = steps_r;
    status_nxt     = status_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    v_we           = 1'b0;
    l_we           = 1'b0;
    l_waddr        = node_r[AW-1:0];
    l_wdata        = NULL_IDX;
    raddr          = cur_r[AW-1:0];
    in_ready       = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt = in_action;
          key_nxt = in_key;
          val_nxt = in_value;
          if (in_action inside {ACT_APPEND, ACT_INS_HEAD}) begin
            state_nxt = S_ALLOC;
          end else if (in_action inside {[ACT_INS_AFTER:ACT_SEARCH]}) begin
            if (head_r >= NULL_IDX) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_FINISH;
            end else begin
              // start the walk at the head node
              raddr     = head_r[AW-1:0];
              cur_nxt   = head_r;
              prev_nxt  = NULL_IDX;
              steps_nxt = '0;
              state_nxt = S_WALK;
            end
          end else begin
            status_nxt = ST_DONE;
            state_nxt  = S_FINISH;
          end
        end
      end

      S_WALK: begin
        // compare the node just read, fetch the next one meanwhile
        if (v_rdata == key_r) begin
          hit_nxt      = cur_r;
          hit_link_nxt = l_rdata;
          if (act_r == ACT_INS_AFTER) begin
            state_nxt = S_ALLOC;
          end else if (act_r == ACT_DELETE) begin
            state_nxt = S_DEL;
          end else begin
            status_nxt = ST_DONE;
            state_nxt  = S_FINISH;
          end
        end else if (l_rdata >= NULL_IDX || steps_r == LAST_STEP) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_FINISH;
        end else begin
          raddr     = l_rdata[AW-1:0];
          prev_nxt  = cur_r;
          cur_nxt   = l_rdata;
          steps_nxt = steps_r + 1'b1;
        end
      end

      S_ALLOC: begin
        // free list first, then untouched nodes
        if (free_r < NULL_IDX) begin
          raddr     = free_r[AW-1:0];
          state_nxt = S_ALLOC_POP;
        end else if (fresh_r < NULL_IDX) begin
          node_nxt  = fresh_r;
          fresh_nxt = fresh_r + 1'b1;
          state_nxt = S_WRITE;
        end else begin
          status_nxt = ST_FULL;
          state_nxt  = S_FINISH;
        end
      end

      S_ALLOC_POP: begin
        node_nxt  = free_r;
        free_nxt  = l_rdata;
        state_nxt = S_WRITE;
      end

      S_WRITE: begin
        // fill the new node
        v_we    = 1'b1;
        l_we    = 1'b1;
        l_waddr = node_r[AW-1:0];
        if (act_r == ACT_INS_HEAD) begin
          l_wdata  = head_r;
          head_nxt = node_r;
          if (tail_r >= NULL_IDX) begin
            tail_nxt = node_r;
          end
          count_nxt  = count_r + 1'b1;
          status_nxt = ST_DONE;
          state_nxt  = S_FINISH;
        end else if (act_r == ACT_APPEND) begin
          l_wdata   = NULL_IDX;
          state_nxt = S_LINK2;
        end else begin
          l_wdata   = hit_link_r;
          state_nxt = S_LINK2;
        end
      end

      S_LINK2: begin
        // hook the new node behind the tail or the hit node
        if (act_r == ACT_APPEND) begin
          if (tail_r < NULL_IDX) begin
            l_we    = 1'b1;
            l_waddr = tail_r[AW-1:0];
            l_wdata = node_r;
          end else begin
            head_nxt = node_r;
          end
          tail_nxt = node_r;
        end else begin
          l_we    = 1'b1;
          l_waddr = hit_r[AW-1:0];
          l_wdata = node_r;
          if (tail_r == hit_r) begin
            tail_nxt = node_r;
          end
        end
        count_nxt  = count_r + 1'b1;
        status_nxt = ST_DONE;
        state_nxt  = S_FINISH;
      end

      S_DEL: begin
        // unlink the hit node
        if (prev_r < NULL_IDX) begin
          l_we    = 1'b1;
          l_waddr = prev_r[AW-1:0];
          l_wdata = hit_link_r;
        end else begin
          head_nxt = hit_link_r;
        end
        if (tail_r == hit_r) begin
          tail_nxt = prev_r;
        end
        state_nxt = S_DEL2;
      end

      S_DEL2: begin
        // push the hit node on the free list
        l_we     = 1'b1;
        l_waddr  = hit_r[AW-1:0];
        l_wdata  = free_r;
        free_nxt = hit_r;
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end
        status_nxt = ST_DONE;
        state_nxt  = S_FINISH;
      end

      S_FINISH: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  // checks
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NULL_IDX && fresh_r <= NULL_IDX)
    else $error("node count or fresh pointer beyond capacity");

  a_head_count : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> ((head_r == NULL_IDX) == (count_r == '0)))
    else $error("head pointer disagrees with node count");

  a_tail_count : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> ((tail_r == NULL_IDX) == (count_r == '0)))
    else $error("tail pointer disagrees with node count");

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted beat did not start work");

  a_result_src : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FINISH)
    else $error("result raised outside finish");

endmodule

### hw/rtl/bsll_ram.sv
`timescale 1ns / 1ps

module bsll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/bsll_checker.sv
`timescale 1ns / 1ps

module bsll_checker #(
  parameter int CAPACITY = bsll_pkg::BSLL_CAPACITY,
  parameter int IW       = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_status,
  input  logic [IW-1:0]      out_count,
  output int                 fail_count,
  output int                 pending,
  output int                 checked,
  output int                 peak_count,
  output int                 full_seen,
  output int                 empty_seen
);
  import bsll_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  typedef struct packed {
    status_t       status;
    logic [IW-1:0] count;
  } list_result_t;

  // results predicted for accepted beats, oldest first
  list_result_t result_q[$];

  // shadow copy of the node store and the list registers
  logic signed [31:0] node_val [CAPACITY];
  logic [IW-1:0]      node_nxt [CAPACITY];
  logic [IW-1:0]      head_ix;
  logic [IW-1:0]      tail_ix;
  logic [IW-1:0]      free_ix;
  logic [IW-1:0]      fresh_ix;
  logic [IW-1:0]      depth;

  // free list first, then never-used nodes; NIL when the store is full
  task automatic grab_node(output logic [IW-1:0] n);
    if (free_ix < CAPACITY) begin
      n = free_ix;
      free_ix = node_nxt[free_ix[AW-1:0]];
    end else if (fresh_ix < CAPACITY) begin
      n = fresh_ix;
      fresh_ix = fresh_ix + 1'b1;
    end else begin
      n = NIL;
    end
  endtask

  // first node in list order holding the key, and the node in front of it
  task automatic find_first(input logic signed [31:0] k, output logic [IW-1:0] hit,
                            output logic [IW-1:0] prev);
    logic [IW-1:0] cur;
    logic [IW-1:0] last;
    int steps;
    cur = head_ix;
    last = NIL;
    steps = 0;
    hit = NIL;
    prev = NIL;
    while (cur < CAPACITY && steps < CAPACITY && hit == NIL) begin
      if (node_val[cur[AW-1:0]] == k) begin
        hit = cur;
        prev = last;
      end else begin
        last = cur;
        cur = node_nxt[cur[AW-1:0]];
      end
      steps++;
    end
  endtask

  // apply one action to the shadow list and give the expected result
  task automatic apply_action(input logic [2:0] act, input logic signed [31:0] k,
                              input logic signed [31:0] v, output list_result_t r);
    logic [IW-1:0] n;
    logic [IW-1:0] hit;
    logic [IW-1:0] prev;
    status_t st;
    st = ST_DONE;
    if (act == ACT_APPEND || act == ACT_INS_HEAD) begin
      grab_node(n);
      if (n >= CAPACITY) begin
        st = ST_FULL;
      end else begin
        node_val[n[AW-1:0]] = v;
        if (act == ACT_APPEND) begin
          node_nxt[n[AW-1:0]] = NIL;
          if (tail_ix < CAPACITY) node_nxt[tail_ix[AW-1:0]] = n;
          else head_ix = n;
          tail_ix = n;
        end else begin
          node_nxt[n[AW-1:0]] = head_ix;
          head_ix = n;
          if (tail_ix >= CAPACITY) tail_ix = n;
        end
        depth = depth + 1'b1;
      end
    end else if (act == ACT_INS_AFTER || act == ACT_DELETE || act == ACT_SEARCH) begin
      if (head_ix >= CAPACITY) begin
        st = ST_EMPTY;
      end else begin
        find_first(k, hit, prev);
        // key is checked before room, so a full list without the key is not-found
        if (hit >= CAPACITY) begin
          st = ST_NOT_FOUND;
        end else if (act == ACT_INS_AFTER) begin
          grab_node(n);
          if (n >= CAPACITY) begin
            st = ST_FULL;
          end else begin
            node_val[n[AW-1:0]] = v;
            node_nxt[n[AW-1:0]] = node_nxt[hit[AW-1:0]];
            node_nxt[hit[AW-1:0]] = n;
            if (tail_ix == hit) tail_ix = n;
            depth = depth + 1'b1;
          end
        end else if (act == ACT_DELETE) begin
          if (prev < CAPACITY) node_nxt[prev[AW-1:0]] = node_nxt[hit[AW-1:0]];
          else head_ix = node_nxt[hit[AW-1:0]];
          if (tail_ix == hit) tail_ix = prev;
          node_nxt[hit[AW-1:0]] = free_ix;
          free_ix = hit;
          if (depth != 0) depth = depth - 1'b1;
        end
      end
    end
    // unknown actions leave everything as it is and report done
    r.status = st;
    r.count = depth;
  endtask

  // sample both channels at the edge, compare the result beat, predict the input beat
  always @(posedge clk) begin : monitor
    list_result_t want;
    list_result_t oldest;
    if (!rst_n) begin
      head_ix = NIL;
      tail_ix = NIL;
      free_ix = NIL;
      fresh_ix = '0;
      depth = '0;
      result_q.delete();
      fail_count = 0;
      checked = 0;
      peak_count = 0;
      full_seen = 0;
      empty_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result beat with no action waiting: status %0d count %0d",
                 out_status, out_count);
          fail_count++;
        end else begin
          oldest = result_q.pop_front();
          checked++;
          if (out_status !== oldest.status) begin
            $error("out_status: expected %0d, actual %0d", oldest.status, out_status);
            fail_count++;
          end
          if (out_count !== oldest.count) begin
            $error("out_count: expected %0d, actual %0d", oldest.count, out_count);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_action(in_action, in_key, in_value, want);
        result_q.push_back(want);
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_EMPTY) empty_seen++;
        if (int'(depth) > peak_count) peak_count = int'(depth);
      end
    end
    pending = result_q.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import bsll_pkg::*;

  localparam int CAPACITY   = BSLL_CAPACITY;
  localparam int IW         = $clog2(CAPACITY + 1);
  localparam int ITEMS      = 1200;
  localparam int MAX_GAP    = 18;
  localparam int HOLD_AT    = 150;
  localparam int HOLD_LEN   = 400;
  localparam int SETTLE     = 2 * CAPACITY + 20;
  localparam int IDLE_LIMIT = 4000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_action;
  logic signed [31:0] in_key;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic [IW-1:0]      out_count;

  int fail_count;
  int pending;
  int checked;
  int peak_count;
  int full_seen;
  int empty_seen;

  int sent;
  int directed_sent;
  bit burst;

  // a few values repeat on purpose so that keys match more than one node
  logic signed [31:0] value_pool [16];
  // values offered by recent insert beats, source of keys that hit
  logic signed [31:0] live_vals [$];

  bounded_singly_linked_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_key     (in_key),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_count  (out_count)
  );

  bsll_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_key     (in_key),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_count  (out_count),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .peak_count (peak_count),
    .full_seen  (full_seen),
    .empty_seen (empty_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input logic [2:0] act, input logic signed [31:0] k,
                           input logic signed [31:0] v);
    int gap;
    bit took;
    gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_key <= k;
    in_value <= v;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  // stop offering until every predicted result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin : sink
    int hold_cycles;
    int quiet;
    int got;
    bit took;
    out_ready <= 1'b0;
    got = 0;
    quiet = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (got == HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        hold_cycles = (quiet > 0) ? 0 : $urandom_range(0, MAX_GAP);
        if (quiet > 0) quiet--;
        else if ($urandom_range(0, 49) == 0) quiet = 30;
        if (hold_cycles > 0) begin
          out_ready <= 1'b0;
          repeat (hold_cycles) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
      got++;
    end
  end

  // watchdog on cycles without any beat
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // stimulus and verdict
  initial begin : stim
    int counted;
    int phase;
    int phase_kind;
    int phase_len;
    int r;
    int idx;
    int total_fail;
    bit from_live;
    logic [2:0] act;
    logic signed [31:0] k;
    logic signed [31:0] v;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_APPEND;
    in_key <= '0;
    in_value <= '0;
    sent = 0;
    burst = 1'b0;

    value_pool[0] = 32'sh7fffffff;
    value_pool[1] = 32'sh80000000;
    value_pool[2] = 32'sh00000000;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < 16; i++) value_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, unknown actions, then a short list walked at head, middle and tail
    send_beat(ACT_SEARCH, 32'sd5, 32'sd0);
    send_beat(ACT_DELETE, 32'sd5, 32'sd0);
    send_beat(ACT_INS_AFTER, 32'sd5, 32'sd9);
    send_beat(3'd5, 32'sh7fffffff, 32'sh80000000);
    send_beat(3'd6, 32'sh80000000, 32'sh7fffffff);
    send_beat(3'd7, -32'sd1, -32'sd1);
    send_beat(ACT_APPEND, 32'sd0, 32'sh7fffffff);
    send_beat(ACT_INS_HEAD, 32'sd0, 32'sh80000000);
    send_beat(ACT_APPEND, 32'sd0, 32'sd0);
    send_beat(ACT_INS_AFTER, 32'sh7fffffff, -32'sd1);
    send_beat(ACT_INS_AFTER, 32'sd0, 32'sh55555555);
    send_beat(ACT_APPEND, 32'sd0, 32'shaaaaaaaa);
    send_beat(ACT_SEARCH, 32'sh80000000, 32'sd0);
    send_beat(ACT_SEARCH, 32'sd12345, 32'sd0);
    send_beat(ACT_INS_AFTER, 32'sd12345, 32'sd1);
    send_beat(ACT_INS_HEAD, 32'sd0, 32'sd0);
    send_beat(ACT_DELETE, 32'sd0, 32'sd0);
    send_beat(ACT_DELETE, 32'shaaaaaaaa, 32'sd0);
    send_beat(ACT_APPEND, 32'sd0, 32'sd7);
    send_beat(ACT_DELETE, -32'sd1, 32'sd0);
    send_beat(ACT_DELETE, 32'sh80000000, 32'sd0);
    send_beat(ACT_SEARCH, 32'sd0, 32'sd0);
    send_beat(ACT_DELETE, 32'sd12345, 32'sd0);
    directed_sent = sent;
    wait_for_results();

    // random phases: grow, shrink or mixed; keys mostly drawn from live values
    counted = 0;
    phase = 0;
    while (counted < ITEMS) begin
      phase_kind = (phase == 0) ? 0 : $urandom_range(0, 2);
      phase_len = (phase == 0) ? 120 : $urandom_range(40, 120);
      burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < phase_len && counted < ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          act = 3'($urandom_range(5, 7));
        end else if (phase_kind == 0) begin
          act = (r < 38) ? ACT_APPEND : (r < 60) ? ACT_INS_HEAD :
                (r < 85) ? ACT_INS_AFTER : (r < 93) ? ACT_DELETE : ACT_SEARCH;
        end else if (phase_kind == 1) begin
          act = (r < 8) ? ACT_APPEND : (r < 12) ? ACT_INS_HEAD :
                (r < 17) ? ACT_INS_AFTER : (r < 85) ? ACT_DELETE : ACT_SEARCH;
        end else begin
          act = (r < 22) ? ACT_APPEND : (r < 40) ? ACT_INS_HEAD :
                (r < 60) ? ACT_INS_AFTER : (r < 80) ? ACT_DELETE : ACT_SEARCH;
        end

        r = $urandom_range(0, 99);
        from_live = 1'b0;
        idx = 0;
        if (r < 70 && live_vals.size() > 0) begin
          idx = $urandom_range(0, live_vals.size() - 1);
          k = live_vals[idx];
          from_live = 1'b1;
        end else if (r < 85) begin
          k = value_pool[$urandom_range(0, 15)];
        end else begin
          k = $urandom;
        end
        v = ($urandom_range(0, 1) == 0) ? value_pool[$urandom_range(0, 15)] : $urandom;

        // keep the bag of live values roughly in step with the list
        if (act == ACT_APPEND || act == ACT_INS_HEAD || act == ACT_INS_AFTER) begin
          live_vals.push_back(v);
          if (live_vals.size() > 100) live_vals.pop_front();
        end else if (act == ACT_DELETE && from_live) begin
          live_vals.delete(idx);
        end

        send_beat(act, k, v);
        if (act <= ACT_SEARCH) counted++;
      end
      burst = 1'b0;
      if (phase == 2 || $urandom_range(0, 2) == 0) wait_for_results();
      phase++;
    end

    // drain and let any late beat show up
    wait_for_results();
    repeat (SETTLE) @(posedge clk);

    total_fail = fail_count;
    if (pending != 0) begin
      $error("%0d predicted results never arrived", pending);
      total_fail += pending;
    end
    $display("sent %0d beats (%0d directed), checked %0d results", sent, directed_sent,
             checked);
    $display("list depth peaked at %0d of %0d nodes; full %0d times, empty %0d times",
             peak_count, CAPACITY, full_seen, empty_seen);
    if (total_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
